// ===== hw/rtl/cqe_pkg.sv =====
// Shared widths and codes for the circular queue engine.
package cqe_pkg;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int QSIZE_W  = 7;

  // Size register value after reset
  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 7'd64;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== hw/rtl/circular_queue_engine_top.sv =====
// Insert, remove and unused-kind results, and the first dump result, are registered and
// appear in the cycle after the request transfer (strobe result_valid). Requests are
// taken one per cycle while busy is low; a dump reads one slot of the item memory per cycle
// and holds busy high until its final result. The receiver cannot stall results.
// Reset (rst, synchronous): queue empty, head and tail at slot 0, queue_size 64; item
// memory contents are not cleared and no clearing pass is run.
module circular_queue_engine_top #(
  parameter int MAX_DEPTH  = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cqe_pkg::KIND_W-1:0]        kind,
  input  logic signed [cqe_pkg::DATA_W-1:0] item_value,
  input  logic                              cfg_we,
  input  logic [cqe_pkg::QSIZE_W-1:0]       cfg_data,
  output logic                              result_valid,
  output logic [cqe_pkg::STATUS_W-1:0]      status,
  output logic signed [cqe_pkg::DATA_W-1:0] data_value,
  output logic                              last_of_run
);
  import cqe_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = (AW + 1 > QSIZE_W) ? AW + 1 : QSIZE_W;
  localparam logic [AW:0] DEPTH_LIM = (AW + 1)'(MAX_DEPTH);
  localparam logic [CW-1:0] DEPTH_CMP = CW'(MAX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  // Item memory
  logic [ITEM_WIDTH-1:0] mem [MAX_DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data;

  // Control registers
  state_t             state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic               is_empty, is_empty_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW:0]        cnt, cnt_next;
  logic [QSIZE_W-1:0] queue_size;

  // Result registers
  logic                res_valid_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                res_last, res_last_next;
  logic                res_mem, res_mem_next;

  // Memory access controls
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic          accept;
  logic          dump_last;
  logic [CW-1:0] qs_ext;
  logic [AW:0]   lim;
  logic [ITEM_WIDTH+DATA_W-1:0] rd_ext;

  // Step an index forward, wrapping at the number of slots in use
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] i, input logic [AW:0] l);
    logic [AW:0] nxt;
    nxt = {1'b0, i} + 1'b1;
    return (nxt >= l) ? '0 : nxt[AW-1:0];
  endfunction

  // Clamp the size register to 1..MAX_DEPTH
  assign qs_ext = CW'(queue_size);
  always_comb begin
    if (queue_size == '0) begin
      lim = (AW + 1)'(1);
    end else if (qs_ext > DEPTH_CMP) begin
      lim = DEPTH_LIM;
    end else begin
      lim = qs_ext[AW:0];
    end
  end

  assign busy   = (state == S_DUMP);
  assign accept = start && !busy;

  // Request decode and queue pointer update
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    is_empty_next   = is_empty;
    idx_next        = idx;
    cnt_next        = cnt;
    res_valid_next  = 1'b0;
    res_status_next = ST_OK;
    res_last_next   = 1'b1;
    res_mem_next    = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = adv(tail, lim);
    rd_en           = 1'b0;
    rd_addr         = head;
    dump_last       = 1'b1;

    if (state == S_DUMP) begin
      // Walk one slot per cycle until the tail or the slot count is reached
      rd_en          = 1'b1;
      rd_addr        = idx;
      dump_last      = (idx == tail) || (cnt + 1'b1 == lim);
      res_valid_next = 1'b1;
      res_mem_next   = 1'b1;
      res_last_next  = dump_last;
      if (dump_last) begin
        state_next = S_IDLE;
      end else begin
        idx_next = adv(idx, lim);
        cnt_next = cnt + 1'b1;
      end
    end else if (accept) begin
      res_valid_next = 1'b1;
      case (kind)
        KIND_INSERT: begin
          if (!is_empty && adv(tail, lim) == head) begin
            res_status_next = ST_FULL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = is_empty ? '0 : adv(tail, lim);
            tail_next     = wr_addr;
            is_empty_next = 1'b0;
            if (is_empty) begin
              head_next = '0;
            end
          end
        end
        KIND_REMOVE: begin
          if (is_empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            res_mem_next = 1'b1;
            if (head == tail) begin
              head_next     = '0;
              tail_next     = '0;
              is_empty_next = 1'b1;
            end else begin
              head_next = adv(head, lim);
            end
          end
        end
        KIND_DUMP: begin
          if (is_empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en         = 1'b1;
            res_mem_next  = 1'b1;
            dump_last     = (head == tail) || (lim == (AW + 1)'(1));
            res_last_next = dump_last;
            if (!dump_last) begin
              state_next = S_DUMP;
              idx_next   = adv(head, lim);
              cnt_next   = (AW + 1)'(1);
            end
          end
        end
        default: begin
          res_status_next = ST_OK;
        end
      endcase
    end

    // Empty the queue on a size write
    if (cfg_we) begin
      head_next     = '0;
      tail_next     = '0;
      is_empty_next = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      is_empty     <= 1'b1;
      idx          <= '0;
      cnt          <= '0;
      queue_size   <= QSIZE_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      tail         <= tail_next;
      is_empty     <= is_empty_next;
      idx          <= idx_next;
      cnt          <= cnt_next;
      result_valid <= res_valid_next;
      if (cfg_we) begin
        queue_size <= cfg_data;
      end
    end
  end

  // Register result fields
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res_mem    <= res_mem_next;
  end

  // Item memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= ITEM_WIDTH'({{ITEM_WIDTH{1'b0}}, item_value});
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Drive result ports; stored items are zero-extended or cut to 32 bits
  assign rd_ext      = {{DATA_W{1'b0}}, rd_data};
  assign status      = res_status;
  assign last_of_run = res_last;
  assign data_value  = res_mem ? $signed(rd_ext[DATA_W-1:0]) : '0;

  // Every non-dump transfer gives a result in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (accept && kind != KIND_DUMP) |=> result_valid)
    else $error("missing result after request transfer");

  // A dump walk emits a result in every cycle
  a_dump_streams: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_valid)
    else $error("dump walk skipped a cycle");

  // Leaving the dump walk coincides with the final result
  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (result_valid && last_of_run))
    else $error("dump ended without last_of_run");

  // An empty queue keeps both pointers at slot zero
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0 && tail == '0))
    else $error("empty queue with nonzero pointers");

  // A dump only starts on a nonempty queue
  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (!busy && state_next == S_DUMP) |-> !is_empty)
    else $error("dump walk started on empty queue");

endmodule
